>>> design/bagd_pkg.sv
// Shared types and constants for the beat, apex and start gesture detector.
`timescale 1ns / 1ps
`default_nettype none
package bagd_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_THRESHOLD     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_VERTICAL_EXTENT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORTEST_GESTURE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONGEST_GESTURE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GESTURE_ENABLE      = 3'd4;

	localparam logic [14:0] RST_SPEED_THRESHOLD     = 15'd100;
	localparam logic [15:0] RST_MIN_VERTICAL_EXTENT = 16'd200;
	localparam logic [31:0] RST_SHORTEST_GESTURE    = 32'd150000;
	localparam logic [31:0] RST_LONGEST_GESTURE     = 32'd750000;
	localparam logic        RST_GESTURE_ENABLE      = 1'b1;

	localparam logic [1:0] SIGN_ZERO = 2'd0;
	localparam logic [1:0] SIGN_POS  = 2'd1;
	localparam logic [1:0] SIGN_NEG  = 2'd2;

	typedef struct packed {
		logic [14:0] speed_threshold;
		logic [15:0] min_vertical_extent;
		logic [31:0] shortest_gesture;
		logic [31:0] longest_gesture;
		logic        gesture_enable;
	} cfg_t;

	// One sample after the squaring stage.
	typedef struct packed {
		logic        [31:0] sample_time;
		logic signed [15:0] pos_y;
		logic        [1:0]  vy_sign;
		logic        [30:0] sq_x;
		logic        [30:0] sq_y;
		logic        [30:0] sq_z;
		logic        [29:0] thr_sq;
	} stage_t;

endpackage
`default_nettype wire

>>> design/bagd_if.sv
// Request channels for motion samples and detector results.
`timescale 1ns / 1ps
`default_nettype none
interface bagd_sample_if;
	logic               valid;
	logic               ready;
	logic        [31:0] sample_time;
	logic signed [15:0] pos_y;
	logic signed [15:0] vel_x;
	logic signed [15:0] vel_y;
	logic signed [15:0] vel_z;

	modport source (output valid, sample_time, pos_y, vel_x, vel_y, vel_z, input ready);
	modport sink   (input valid, sample_time, pos_y, vel_x, vel_y, vel_z, output ready);
endinterface

interface bagd_result_if;
	logic        valid;
	logic        ready;
	logic        beat;
	logic        apex;
	logic        start_gesture;
	logic [31:0] gesture_beat_time;
	logic [31:0] estimated_time;

	modport source (output valid, beat, apex, start_gesture, gesture_beat_time,
		estimated_time, input ready);
	modport sink   (input valid, beat, apex, start_gesture, gesture_beat_time,
		estimated_time, output ready);
endinterface
`default_nettype wire

>>> design/bagd_cfg.sv
// Configuration register bank.
`timescale 1ns / 1ps
`default_nettype none
module bagd_cfg (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [bagd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [bagd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output bagd_pkg::cfg_t                      cfg
);

	bagd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_threshold     <= bagd_pkg::RST_SPEED_THRESHOLD;
			cfg_q.min_vertical_extent <= bagd_pkg::RST_MIN_VERTICAL_EXTENT;
			cfg_q.shortest_gesture    <= bagd_pkg::RST_SHORTEST_GESTURE;
			cfg_q.longest_gesture     <= bagd_pkg::RST_LONGEST_GESTURE;
			cfg_q.gesture_enable      <= bagd_pkg::RST_GESTURE_ENABLE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bagd_pkg::CFG_SPEED_THRESHOLD: begin
					cfg_q.speed_threshold <= cfg_wdata[14:0];
				end
				bagd_pkg::CFG_MIN_VERTICAL_EXTENT: begin
					cfg_q.min_vertical_extent <= cfg_wdata[15:0];
				end
				bagd_pkg::CFG_SHORTEST_GESTURE: begin
					cfg_q.shortest_gesture <= cfg_wdata[31:0];
				end
				bagd_pkg::CFG_LONGEST_GESTURE: begin
					cfg_q.longest_gesture <= cfg_wdata[31:0];
				end
				bagd_pkg::CFG_GESTURE_ENABLE: begin
					cfg_q.gesture_enable <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> design/bagd_speed.sv
// Input register and squaring stage: velocity squares and squared threshold.
`timescale 1ns / 1ps
`default_nettype none
module bagd_speed (
	input  wire              clk,
	input  wire              arst_n,
	bagd_sample_if.sink      sample_in,
	input  wire  [14:0]      speed_threshold,
	output bagd_pkg::stage_t stage,
	output logic             stage_valid,
	input  wire              stage_take
);

	logic               v_s1;
	logic        [31:0] time_s1;
	logic signed [15:0] pos_y_s1;
	logic signed [15:0] vx_s1;
	logic signed [15:0] vy_s1;
	logic signed [15:0] vz_s1;

	logic             v_s2;
	bagd_pkg::stage_t data_s2;

	logic adv_s2;
	logic adv_s1;
	logic signed [31:0] prod_x;
	logic signed [31:0] prod_y;
	logic signed [31:0] prod_z;
	logic [29:0] thr_prod;
	logic [1:0]  sign_s1;

	assign adv_s2 = !v_s2 || stage_take;
	assign adv_s1 = !v_s1 || adv_s2;
	assign sample_in.ready = adv_s1;

	assign prod_x   = vx_s1 * vx_s1;
	assign prod_y   = vy_s1 * vy_s1;
	assign prod_z   = vz_s1 * vz_s1;
	assign thr_prod = speed_threshold * speed_threshold;

	always_comb begin
		if (vy_s1 > 16'sd0) begin
			sign_s1 = bagd_pkg::SIGN_POS;
		end else if (vy_s1 < 16'sd0) begin
			sign_s1 = bagd_pkg::SIGN_NEG;
		end else begin
			sign_s1 = bagd_pkg::SIGN_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= sample_in.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && sample_in.valid) begin
			time_s1  <= sample_in.sample_time;
			pos_y_s1 <= sample_in.pos_y;
			vx_s1    <= sample_in.vel_x;
			vy_s1    <= sample_in.vel_y;
			vz_s1    <= sample_in.vel_z;
		end
		if (adv_s2 && v_s1) begin
			data_s2.sample_time <= time_s1;
			data_s2.pos_y       <= pos_y_s1;
			data_s2.vy_sign     <= sign_s1;
			data_s2.sq_x        <= prod_x[30:0];
			data_s2.sq_y        <= prod_y[30:0];
			data_s2.sq_z        <= prod_z[30:0];
			data_s2.thr_sq      <= thr_prod;
		end
	end

	assign stage       = data_s2;
	assign stage_valid = v_s2;

endmodule
`default_nettype wire

>>> design/bagd_track.sv
// Turn detection, range and apex tracking, gesture check and result register.
`timescale 1ns / 1ps
`default_nettype none
module bagd_track (
	input  wire              clk,
	input  wire              arst_n,
	input  bagd_pkg::cfg_t   cfg,
	input  bagd_pkg::stage_t stage,
	input  wire              stage_valid,
	output logic             stage_take,
	bagd_result_if.source    result_out
);

	logic               out_valid_q;
	logic               beat_q;
	logic               apex_q;
	logic               start_q;
	logic        [31:0] gbt_q;
	logic        [31:0] est_q;

	logic [1:0]         prev_sign_q;
	logic               have_beat_q;
	logic [31:0]        beat_time_q;
	logic               have_apex_q;
	logic [31:0]        apex_time_q;
	logic signed [15:0] y_low_q;
	logic signed [15:0] y_high_q;

	logic               move;
	logic [31:0]        spd_sq;
	logic               fast;
	logic               beat;
	logic               apex;
	logic               have_beat_n;
	logic [31:0]        beat_time_n;
	logic               have_apex_n;
	logic [31:0]        apex_time_n;
	logic signed [15:0] y_low_n;
	logic signed [15:0] y_high_n;
	logic signed [16:0] extent;
	logic [31:0]        len;
	logic               start;

	assign stage_take = !out_valid_q || result_out.ready;
	assign move       = stage_valid && stage_take;

	assign spd_sq = {1'b0, stage.sq_x} + {1'b0, stage.sq_y} + {1'b0, stage.sq_z};
	assign fast   = spd_sq > {2'b00, stage.thr_sq};
	assign beat   = fast && (prev_sign_q == bagd_pkg::SIGN_NEG)
		&& (stage.vy_sign == bagd_pkg::SIGN_POS);
	assign apex   = fast && (prev_sign_q == bagd_pkg::SIGN_POS)
		&& (stage.vy_sign == bagd_pkg::SIGN_NEG);

	always_comb begin
		y_low_n     = y_low_q;
		y_high_n    = y_high_q;
		have_beat_n = have_beat_q;
		beat_time_n = beat_time_q;
		have_apex_n = have_apex_q;
		apex_time_n = apex_time_q;
		if (have_beat_q) begin
			if (stage.pos_y < y_low_q) begin
				y_low_n = stage.pos_y;
			end
			if (stage.pos_y > y_high_q) begin
				y_high_n = stage.pos_y;
			end
		end
		// a new beat restarts the range and drops any apex seen so far
		if (beat) begin
			have_beat_n = 1'b1;
			beat_time_n = stage.sample_time;
			have_apex_n = 1'b0;
			y_low_n     = stage.pos_y;
			y_high_n    = stage.pos_y;
		end
		if (apex && have_beat_n && !have_apex_n) begin
			have_apex_n = 1'b1;
			apex_time_n = stage.sample_time;
		end
	end

	// range is never negative once a beat has been seen
	assign extent = {y_high_n[15], y_high_n} - {y_low_n[15], y_low_n};
	assign len    = apex_time_n - beat_time_n;
	assign start  = cfg.gesture_enable && have_beat_n && have_apex_n
		&& (extent[15:0] >= cfg.min_vertical_extent)
		&& (len <= cfg.longest_gesture) && (len >= cfg.shortest_gesture);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			prev_sign_q <= bagd_pkg::SIGN_ZERO;
			have_beat_q <= 1'b0;
			beat_time_q <= '0;
			have_apex_q <= 1'b0;
			apex_time_q <= '0;
			y_low_q     <= '0;
			y_high_q    <= '0;
		end else begin
			if (stage_take) begin
				out_valid_q <= stage_valid;
			end
			if (move) begin
				prev_sign_q <= stage.vy_sign;
				have_beat_q <= have_beat_n;
				beat_time_q <= beat_time_n;
				have_apex_q <= have_apex_n;
				apex_time_q <= apex_time_n;
				y_low_q     <= y_low_n;
				y_high_q    <= y_high_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			beat_q  <= beat;
			apex_q  <= apex;
			start_q <= start;
			gbt_q   <= start ? beat_time_n : 32'd0;
			est_q   <= start ? (apex_time_n + len) : 32'd0;
		end
	end

	assign result_out.valid             = out_valid_q;
	assign result_out.beat              = beat_q;
	assign result_out.apex              = apex_q;
	assign result_out.start_gesture     = start_q;
	assign result_out.gesture_beat_time = gbt_q;
	assign result_out.estimated_time    = est_q;

`ifndef SYNTHESIS
	a_beat_apex_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(beat_q && apex_q))
		else $error("beat and apex flagged on one sample");

	a_times_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !start_q) |-> (gbt_q == 32'd0 && est_q == 32'd0))
		else $error("time fields nonzero without start gesture");

	a_apex_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		have_apex_q |-> have_beat_q)
		else $error("apex kept without a beat");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!move |=> ($stable(have_beat_q) && $stable(prev_sign_q) && $stable(apex_time_q)))
		else $error("tracking state changed without a request");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		have_beat_q |-> (y_low_q <= y_high_q))
		else $error("vertical range inverted");
`endif

endmodule
`default_nettype wire

>>> design/beat_apex_start_gesture_detector_unit.sv
// Top level of the beat, apex and start gesture detector.
`timescale 1ns / 1ps
`default_nettype none
// Takes one motion sample per request and returns exactly one result per
// sample, in order. Throughput is one sample per clock while the result side
// gives no back pressure. A sample passes the input register, which takes it
// at the edge that accepts it, then the squaring register and then the result
// register. The three velocity squares get a register stage of their own.
// The tracking state (last vertical velocity sign, beat and apex times,
// vertical range) is updated within the last stage, so consecutive samples
// never wait on each other. Back pressure on the result side fills the
// pipeline before sample_in.ready drops. Configuration writes must happen
// only while no sample is in flight.
module beat_apex_start_gesture_detector_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [bagd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [bagd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	bagd_sample_if.sink                      sample_in,
	bagd_result_if.source                    result_out
);

	bagd_pkg::cfg_t   cfg;
	bagd_pkg::stage_t stage;
	logic             stage_valid;
	logic             stage_take;

	bagd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bagd_speed u_speed (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_in       (sample_in),
		.speed_threshold (cfg.speed_threshold),
		.stage           (stage),
		.stage_valid     (stage_valid),
		.stage_take      (stage_take)
	);

	bagd_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.stage       (stage),
		.stage_valid (stage_valid),
		.stage_take  (stage_take),
		.result_out  (result_out)
	);

endmodule
`default_nettype wire
